FILE: rtl/branch_target_buffer_2bit_defines.svh
// ----------------------------------------------------------------------------
// Branch target buffer assertion macros
// Clocked property wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef BRANCH_TARGET_BUFFER_2BIT_DEFINES_SVH
`define BRANCH_TARGET_BUFFER_2BIT_DEFINES_SVH

// Checked only while out of reset
`define BTB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included
`define BTB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/bte_pkg.sv
// ----------------------------------------------------------------------------
// Branch target buffer package
// Entry layout, counter codes, item codes and channel widths.
// ----------------------------------------------------------------------------
`default_nettype none

package bte_pkg;

  localparam int PC_W         = 32;
  localparam int WORD_W       = PC_W - 2;  // pc without the byte offset
  localparam int IN_TDATA_W   = 72;        // pc, taken, jump_target, padded
  localparam int OUT_TDATA_W  = 40;        // predict_taken, next_pc, padded

  // item kind carried on in_tuser
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  // 2-bit counter codes
  localparam logic [1:0] CTR_STRONG_NT = 2'd0;
  localparam logic [1:0] CTR_WEAK_NT   = 2'd1;
  localparam logic [1:0] CTR_WEAK_T    = 2'd2;
  localparam logic [1:0] CTR_STRONG_T  = 2'd3;

  localparam logic [PC_W-1:0] PC_STEP = 32'd4;

  typedef struct packed {
    logic            valid;
    logic [PC_W-1:0] tag;
    logic [PC_W-1:0] target;
    logic [1:0]      ctr;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [1:0] train(input logic [1:0] ctr, input logic was_taken);
    logic [1:0] res;
    if (was_taken) begin
      res = (ctr == CTR_STRONG_NT) ? CTR_WEAK_NT : CTR_STRONG_T;
    end else begin
      res = (ctr == CTR_STRONG_T) ? CTR_WEAK_T : CTR_STRONG_NT;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bte_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bte_index.sv
// ----------------------------------------------------------------------------
// Branch target buffer set index
// Word address modulo ENTRIES by reciprocal multiply and one correction.
// ----------------------------------------------------------------------------
`default_nettype none

module bte_index #(
  parameter int ENTRIES = 1024
) (
  input  wire logic                       clk,
  input  wire logic [bte_pkg::WORD_W-1:0] word,  // must hold for two cycles
  output logic      [$clog2(ENTRIES)-1:0] idx    // valid once prod_r and qe_r have registered
);

  localparam int W     = bte_pkg::WORD_W;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int ENT_W = $clog2(ENTRIES + 1);

  // floor(2^W / ENTRIES): the quotient estimate is low by at most one
  localparam logic [W-1:0]     RECIP = W'((64'd1 << W) / ENTRIES);
  localparam logic [ENT_W-1:0] ENT_K = ENT_W'(ENTRIES);
  localparam logic [W-1:0]     ENT_W30 = W'(ENTRIES);

  logic [2*W-1:0]     prod_r;
  logic [W-1:0]       quo;
  logic [W+ENT_W-1:0] qe_full;
  logic [W-1:0]       qe_r;
  logic [W-1:0]       rem;
  logic [W-1:0]       rem_fix;

  assign quo     = prod_r[2*W-1:W];
  assign qe_full = quo * ENT_K;

  always_ff @(posedge clk) begin
    prod_r <= word * RECIP;
    qe_r   <= qe_full[W-1:0];
  end

  assign rem     = word - qe_r;
  assign rem_fix = (rem >= ENT_W30) ? (rem - ENT_W30) : rem;
  assign idx     = rem_fix[IDX_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/branch_target_buffer_2bit.sv
// ----------------------------------------------------------------------------
// Branch target buffer, direct mapped, 2-bit counters
// Predicts next fetch address on lookups and trains the table on updates.
// ----------------------------------------------------------------------------
// Input channel in_*: in_tuser selects lookup (0) or update (1); in_tdata
// carries pc, taken and jump_target. Output channel out_*: one transaction
// per lookup with predict_taken and next_pc; updates return nothing.
// An item steps through ST_IDLE, which takes the transaction, ST_MUL and ST_QUO
// for the index multiply (pc >> 2 modulo ENTRIES), ST_READ for the table read
// and ST_DONE for the compare and write-back or result load; the next item is
// accepted only back in ST_IDLE. One item is worked on at a time, so the table
// needs no forwarding. A lookup result is loaded on leaving ST_DONE into an
// output register; the next item is still accepted while it waits. When the
// receiver stalls, a second lookup holds in its final cycle until the output
// register frees, and in_tready stays low meanwhile.
// After reset the table is swept to invalid, one entry a cycle, through all
// ENTRIES entries, during which in_tready stays low.
// ----------------------------------------------------------------------------
`default_nettype none

module branch_target_buffer_2bit #(
  parameter int ENTRIES = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // pc [31:0], taken [32], jump_target [64:33], zero pad [71:65]
  input  wire logic [bte_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode [0]
  input  wire logic                            in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // predict_taken [0], next_pc [32:1], zero pad [39:33]
  output logic      [bte_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int PC_W  = bte_pkg::PC_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_QUO   = 6'b001000,
    ST_READ  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic               mode_r;
  logic [PC_W-1:0]    pc_r;
  logic               taken_r;
  logic [PC_W-1:0]    tgt_r;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   idx;
  logic               out_valid_r, out_valid_nxt;
  logic               out_taken_r;
  logic [PC_W-1:0]    out_pc_r;

  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  bte_pkg::entry_t             ram_wdata;
  logic [bte_pkg::ENTRY_W-1:0] ram_rdata;
  bte_pkg::entry_t             ent;
  logic                        hit;
  logic                        in_fire;
  logic                        out_free;
  logic                        lookup_done;

  assign in_tready = rst_n && (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  bte_index #(.ENTRIES(ENTRIES)) u_index (
    .clk  (clk),
    .word (pc_r[PC_W-1:2]),
    .idx  (idx)
  );

  bte_ram #(.WIDTH(bte_pkg::ENTRY_W), .DEPTH(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (state_r == ST_READ),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign ent = bte_pkg::entry_t'(ram_rdata);
  assign hit = ent.valid && (ent.tag == pc_r);

  assign lookup_done = (state_r == ST_DONE) && (mode_r == bte_pkg::MODE_LOOKUP) && out_free;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = ent;
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if ((state_r == ST_DONE) && (mode_r == bte_pkg::MODE_UPDATE)) begin
      ram_we = 1'b1;
      if (hit) begin
        ram_wdata.ctr = bte_pkg::train(ent.ctr, taken_r);
      end else begin
        ram_wdata.valid  = 1'b1;
        ram_wdata.tag    = pc_r;
        ram_wdata.target = tgt_r;
        ram_wdata.ctr    = bte_pkg::CTR_WEAK_NT;
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_QUO;
      ST_QUO:  state_nxt = ST_READ;
      ST_READ: state_nxt = ST_DONE;
      ST_DONE: begin
        // hold a lookup until the output register frees
        if (mode_r == bte_pkg::MODE_UPDATE || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (lookup_done) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r  <= in_tuser;
      pc_r    <= in_tdata[31:0];
      taken_r <= in_tdata[32];
      tgt_r   <= in_tdata[64:33];
    end
    if (state_r == ST_READ) begin
      idx_r <= idx;
    end
    if (lookup_done) begin
      if (hit && (ent.ctr >= bte_pkg::CTR_WEAK_T)) begin
        out_taken_r <= 1'b1;
        out_pc_r    <= ent.target;
      end else begin
        out_taken_r <= 1'b0;
        out_pc_r    <= pc_r + bte_pkg::PC_STEP;
      end
    end
  end

  assign out_tvalid = rst_n && out_valid_r;
  assign out_tdata  = {(bte_pkg::OUT_TDATA_W - PC_W - 1)'(0), out_pc_r, out_taken_r};

endmodule

`default_nettype wire

FILE: rtl/bte_checker.sv
// ----------------------------------------------------------------------------
// Branch target buffer port checker
// Watches the top level's channels for timing and reset behaviour.
// ----------------------------------------------------------------------------
`default_nettype none

`include "branch_target_buffer_2bit_defines.svh"

module bte_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [bte_pkg::IN_TDATA_W-1:0]  in_tdata,
  input wire logic                            in_tuser,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [bte_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic in_acc;
  logic lookup_acc;
  logic update_acc;

  assign in_acc     = in_tvalid && in_tready;
  assign lookup_acc = in_acc && (in_tuser == bte_pkg::MODE_LOOKUP);
  assign update_acc = in_acc && (in_tuser == bte_pkg::MODE_UPDATE) && (in_tdata[0] || !in_tdata[0]);

  // table sweep follows every reset
  `BTB_ASSERT_ALWAYS(a_clear_after_rst, clk, !rst_n |=> !in_tready, "ready during table clear")

  `BTB_ASSERT(a_one_at_a_time, clk, rst_n, in_acc |=> !in_tready, "item accepted while busy")

  `BTB_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  `BTB_ASSERT(a_result_from_lookup, clk, rst_n, $rose(out_tvalid) |-> $past(lookup_acc, 5), "result without lookup")

  `BTB_ASSERT(a_update_silent, clk, rst_n, update_acc |-> ##5 !$rose(out_tvalid), "update produced a result")

endmodule

bind branch_target_buffer_2bit bte_checker u_bte_checker (.*);

`default_nettype wire

FILE: tb/btb_pred_checker.sv
// ----------------------------------------------------------------------------
// Branch target buffer prediction checker
// Watches both stream channels, keeps its own copy of the table, predicts the
// result of every accepted lookup and compares it with what the block returns.
// ----------------------------------------------------------------------------
module btb_pred_checker #(
  parameter int ENTRIES = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [bte_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [bte_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                              fail_count,
  output int                              pending,
  output int                              results_seen,
  output int                              taken_seen
);
  import bte_pkg::*;

  typedef struct packed {
    logic            taken;
    logic [PC_W-1:0] npc;
  } prediction_t;

  logic            tbl_valid  [ENTRIES];
  logic [PC_W-1:0] tbl_tag    [ENTRIES];
  logic [PC_W-1:0] tbl_target [ENTRIES];
  logic [1:0]      tbl_ctr    [ENTRIES];
  prediction_t     pred_q [$];

  function automatic logic [1:0] trained_ctr(input logic [1:0] ctr, input logic tk);
    logic [1:0] nxt;
    case (ctr)
      CTR_STRONG_NT: nxt = tk ? CTR_WEAK_NT : CTR_STRONG_NT;
      CTR_STRONG_T:  nxt = tk ? CTR_STRONG_T : CTR_WEAK_T;
      default:       nxt = tk ? CTR_STRONG_T : CTR_STRONG_NT;
    endcase
    return nxt;
  endfunction

  // Train or replace on an update; queue the prediction on a lookup
  task automatic absorb_item(input logic mode, input logic [PC_W-1:0] pc,
                             input logic tk, input logic [PC_W-1:0] tgt);
    int unsigned slot;
    logic        hit;
    prediction_t p;
    slot = (pc >> 2) % ENTRIES;
    hit  = tbl_valid[slot] && (tbl_tag[slot] == pc);
    if (mode == MODE_UPDATE) begin
      if (hit) begin
        tbl_ctr[slot] = trained_ctr(tbl_ctr[slot], tk);
      end else begin
        tbl_valid[slot]  = 1'b1;
        tbl_tag[slot]    = pc;
        tbl_target[slot] = tgt;
        tbl_ctr[slot]    = CTR_WEAK_NT;
      end
    end else begin
      if (hit && tbl_ctr[slot] >= CTR_WEAK_T) begin
        p.taken = 1'b1;
        p.npc   = tbl_target[slot];
      end else begin
        p.taken = 1'b0;
        p.npc   = pc + PC_STEP;
      end
      pred_q.push_back(p);
    end
  endtask

  task automatic check_result(input logic tk, input logic [PC_W-1:0] npc);
    prediction_t exp_p;
    results_seen++;
    if (tk === 1'b1) taken_seen++;
    if (pred_q.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected result, expected none, actual taken=%b next_pc=%h",
               $time, tk, npc);
    end else begin
      exp_p = pred_q.pop_front();
      if (tk !== exp_p.taken || npc !== exp_p.npc) begin
        fail_count++;
        $display("%0t: prediction mismatch, expected taken=%b next_pc=%h, %s",
                 $time, exp_p.taken, exp_p.npc, "actual");
        $display("%0t:   actual taken=%b next_pc=%h", $time, tk, npc);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ENTRIES; k++) tbl_valid[k] = 1'b0;
      pred_q.delete();
      pending <= 0;
    end else begin
      if (out_tvalid && out_tready)
        check_result(out_tdata[0], out_tdata[32:1]);
      if (in_tvalid && in_tready)
        absorb_item(in_tuser, in_tdata[31:0], in_tdata[32], in_tdata[64:33]);
      pending <= pred_q.size();
    end
  end

endmodule

FILE: tb/tb_branch_target_buffer_2bit.sv
// ----------------------------------------------------------------------------
// Branch target buffer testbench
// Drives directed and random lookup/update traffic with random idling on both
// channels and one long receiver hold-off; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_branch_target_buffer_2bit;
  import bte_pkg::*;

  localparam int ENTRIES      = 1024;
  localparam int RANDOM_ITEMS = 1425;
  localparam int CALM_ITEMS   = 150;
  localparam int HOLD_CYCLES  = 200;
  localparam int HOLD_AT_ITEM = 400;
  localparam int POOL_SIZE    = 32;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE       = 20;
  localparam logic [PC_W-1:0] IDX_MASK = 32'h0000_0FFC;  // pc bits [11:2]

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = MODE_LOOKUP;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int   fail_count, pending, results_seen, taken_seen;
  int   n_lookups = 0;
  int   n_updates = 0;
  int   cycles    = 0;
  logic idle_on   = 1'b1;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;

  logic [PC_W-1:0] pool_pc  [POOL_SIZE];
  logic [PC_W-1:0] pool_tgt [POOL_SIZE];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  branch_target_buffer_2bit #(.ENTRIES(ENTRIES)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  btb_pred_checker #(.ENTRIES(ENTRIES)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .taken_seen   (taken_seen)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d predictions outstanding", cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
        out_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one transaction and hold it until accepted; called at a falling edge
  task automatic send_item(input logic mode, input logic [PC_W-1:0] pc,
                           input logic tk, input logic [PC_W-1:0] tgt);
    in_tuser  <= mode;
    in_tdata  <= {{(IN_TDATA_W-65){1'b0}}, tgt, tk, pc};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (mode == MODE_UPDATE) n_updates++;
    else n_lookups++;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  task automatic lookup(input logic [PC_W-1:0] pc);
    send_item(MODE_LOOKUP, pc, 1'($urandom_range(0, 1)), $urandom);
  endtask

  task automatic update(input logic [PC_W-1:0] pc, input logic tk, input logic [PC_W-1:0] tgt);
    send_item(MODE_UPDATE, pc, tk, tgt);
  endtask

  // Working set of branches; each odd one may share its slot with its neighbour
  task automatic refill_pool();
    for (int k = 0; k < POOL_SIZE; k++) begin
      pool_tgt[k] = $urandom;
      if (k % 2 == 1 && $urandom_range(0, 1) == 1)
        pool_pc[k] = ($urandom & ~IDX_MASK) | (pool_pc[k-1] & IDX_MASK);
      else
        pool_pc[k] = $urandom;
    end
  endtask

  initial begin : stimulus
    logic [PC_W-1:0] pc_a, pc_b, pc, tgt;
    logic            mode, tk;
    int unsigned     k;
    pc_a = 32'h1234_5678;
    pc_b = 32'hABCD_E678;  // same slot as pc_a, different tag

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Cold lookups, address wrap
    lookup(32'h0000_0000);
    lookup(32'hFFFF_FFFC);
    lookup(32'hFFFF_FFFF);
    // Walk the counter through every transition on one entry
    update(pc_a, 1'b1, 32'hFFFF_FFFF);
    lookup(pc_a);
    update(pc_a, 1'b1, 32'h0000_0000);
    lookup(pc_a);
    update(pc_a, 1'b0, 32'h0000_0000);
    lookup(pc_a);
    update(pc_a, 1'b1, 32'h0000_0000);
    update(pc_a, 1'b0, 32'h0000_0000);
    update(pc_a, 1'b0, 32'h0000_0000);
    lookup(pc_a);
    update(pc_a, 1'b0, 32'h0000_0000);
    update(pc_a, 1'b1, 32'h0000_0000);
    update(pc_a, 1'b0, 32'h0000_0000);
    update(pc_a, 1'b1, 32'h0000_0000);
    update(pc_a, 1'b1, 32'h0000_0000);
    update(pc_a, 1'b1, 32'h0000_0000);
    // Replace through a conflicting tag
    update(pc_b, 1'b0, 32'h0000_0000);
    lookup(pc_a);
    update(pc_b, 1'b1, 32'hFFFF_FFFF);
    lookup(pc_b);
    // Top slot, all-ones address
    update(32'hFFFF_FFFF, 1'b0, 32'h8000_0001);
    update(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    lookup(32'hFFFF_FFFF);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 200 == 0) refill_pool();
      if (i >= RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
      else if (i % 100 == 0) idle_on = ((i / 100) % 3 != 2);
      if (i == HOLD_AT_ITEM) hold_req = 1'b1;
      k    = $urandom_range(0, POOL_SIZE - 1);
      mode = ($urandom_range(0, 1) == 1) ? MODE_UPDATE : MODE_LOOKUP;
      pc   = ($urandom_range(0, 99) < 12) ? $urandom : pool_pc[k];
      tk   = ($urandom_range(0, 9) < 7);
      tgt  = ($urandom_range(0, 4) == 0) ? $urandom : pool_tgt[k];
      send_item(mode, pc, tk, tgt);
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d lookups and %0d updates, incl. counter walk, slot conflicts, wrap",
             n_lookups, n_updates);
    $display("Checked %0d predictions, %0d taken; one %0d-cycle output stall",
             results_seen, taken_seen, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
